// ===== rtl/vmblk_pkg.sv =====
// shared types, register offsets and constants of the virtio-mmio block register file
package vmblk_pkg;

  localparam int unsigned OffW = 12;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 64;
  localparam int unsigned QlenW = 9;

  // largest queue the device offers
  localparam logic [DataW-1:0] QUEUE_SIZE = 32'd256;

  localparam logic [DataW-1:0] MAGIC_VALUE   = 32'h7472_6976;
  localparam logic [DataW-1:0] VERSION_VALUE = 32'd2;
  localparam logic [DataW-1:0] DEVICE_ID     = 32'd2;
  localparam logic [DataW-1:0] VENDOR_VALUE  = 32'h554D_4551;
  localparam logic [DataW-1:0] SEGMENT_BYTES = 32'd65536;
  localparam logic [DataW-1:0] SEGMENT_COUNT = 32'd254;
  localparam logic [DataW-1:0] SECTOR_BYTES  = 32'd512;

  // version 1, flush, blk size, seg max, size max
  localparam logic [AddrW-1:0] OFFERED_FEATURES = 64'h0000_0001_0000_0246;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SEL_LOW   = 2'd0,
    SEL_HIGH  = 2'd1,
    SEL_OTHER = 2'd2
  } sel_e;

  localparam logic [OffW-1:0] OFF_MAGIC        = 12'h000;
  localparam logic [OffW-1:0] OFF_VERSION      = 12'h004;
  localparam logic [OffW-1:0] OFF_DEVICE_ID    = 12'h008;
  localparam logic [OffW-1:0] OFF_VENDOR_ID    = 12'h00C;
  localparam logic [OffW-1:0] OFF_DEV_FEAT     = 12'h010;
  localparam logic [OffW-1:0] OFF_DEV_FEAT_SEL = 12'h014;
  localparam logic [OffW-1:0] OFF_DRV_FEAT     = 12'h020;
  localparam logic [OffW-1:0] OFF_DRV_FEAT_SEL = 12'h024;
  localparam logic [OffW-1:0] OFF_QUEUE_MAX    = 12'h034;
  localparam logic [OffW-1:0] OFF_QUEUE_NUM    = 12'h038;
  localparam logic [OffW-1:0] OFF_QUEUE_READY  = 12'h044;
  localparam logic [OffW-1:0] OFF_QUEUE_NOTIFY = 12'h050;
  localparam logic [OffW-1:0] OFF_INT_STATUS   = 12'h060;
  localparam logic [OffW-1:0] OFF_INT_ACK      = 12'h064;
  localparam logic [OffW-1:0] OFF_STATUS       = 12'h070;
  localparam logic [OffW-1:0] OFF_DESC_LO      = 12'h080;
  localparam logic [OffW-1:0] OFF_DESC_HI      = 12'h084;
  localparam logic [OffW-1:0] OFF_AVAIL_LO     = 12'h090;
  localparam logic [OffW-1:0] OFF_AVAIL_HI     = 12'h094;
  localparam logic [OffW-1:0] OFF_USED_LO      = 12'h0A0;
  localparam logic [OffW-1:0] OFF_USED_HI      = 12'h0A4;
  localparam logic [OffW-1:0] OFF_CAP_LO       = 12'h100;
  localparam logic [OffW-1:0] OFF_CAP_HI       = 12'h104;
  localparam logic [OffW-1:0] OFF_SEG_SIZE     = 12'h108;
  localparam logic [OffW-1:0] OFF_SEG_MAX      = 12'h10C;
  localparam logic [OffW-1:0] OFF_BLK_SIZE     = 12'h114;

  typedef struct packed {
    logic [1:0]       kind;
    logic [OffW-1:0]  offset;
    logic [DataW-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [AddrW-1:0] feature_bits;
    sel_e             dev_sel;
    sel_e             drv_sel;
    logic [QlenW-1:0] queue_length;
    logic             queue_ready;
    logic [AddrW-1:0] desc_addr;
    logic [AddrW-1:0] avail_addr;
    logic [AddrW-1:0] used_addr;
    logic [DataW-1:0] int_status;
    logic [DataW-1:0] dev_status;
  } state_t;

  function automatic sel_e clamp_select(logic [DataW-1:0] v);
    sel_e s;
    case (v)
      32'd0:   s = SEL_LOW;
      32'd1:   s = SEL_HIGH;
      default: s = SEL_OTHER;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/vmblk_item_if.sv =====
// bus item channel: register read, register write or completion event
interface vmblk_item_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [vmblk_pkg::OffW-1:0]    offset;
  logic [vmblk_pkg::DataW-1:0]   write_data;

  modport source (output valid, kind, offset, write_data, input ready);
  modport sink (input valid, kind, offset, write_data, output ready);
endinterface

// ===== rtl/vmblk_result_if.sv =====
// result item channel: read data and the device-side queue view
interface vmblk_result_if;
  logic                          valid;
  logic                          ready;
  logic [vmblk_pkg::DataW-1:0]   read_data;
  logic                          notify_request;
  logic                          interrupt_line;
  logic                          queue_enabled;
  logic [vmblk_pkg::QlenW-1:0]   queue_depth;
  logic [vmblk_pkg::AddrW-1:0]   descriptor_table_address;
  logic [vmblk_pkg::AddrW-1:0]   available_ring_address;
  logic [vmblk_pkg::AddrW-1:0]   used_ring_address;

  modport source (output valid, read_data, notify_request, interrupt_line, queue_enabled,
                  queue_depth, descriptor_table_address, available_ring_address,
                  used_ring_address, input ready);
  modport sink (input valid, read_data, notify_request, interrupt_line, queue_enabled,
                queue_depth, descriptor_table_address, available_ring_address,
                used_ring_address, output ready);
endinterface

// ===== rtl/vmblk_regs.sv =====
// device state registers and their write-side update
module vmblk_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  vmblk_pkg::item_t            item_i,
  input  logic                        cfg_we_i,
  input  logic [vmblk_pkg::AddrW-1:0] cfg_wdata_i,
  output vmblk_pkg::state_t           state_o,
  output vmblk_pkg::state_t           state_next_o,
  output logic [vmblk_pkg::AddrW-1:0] capacity_o,
  output logic                        notify_o
);

  vmblk_pkg::state_t st_q, st_d;
  logic [vmblk_pkg::AddrW-1:0] cap_q;
  logic [vmblk_pkg::DataW-1:0] wd;
  logic [vmblk_pkg::DataW-1:0] qlen_clamped;

  assign wd = item_i.write_data;
  assign qlen_clamped = (wd < vmblk_pkg::QUEUE_SIZE) ? wd : vmblk_pkg::QUEUE_SIZE;

  always_comb begin
    st_d     = st_q;
    notify_o = 1'b0;
    if (advance_i) begin
      case (item_i.kind)
        vmblk_pkg::KIND_WRITE: begin
          case (item_i.offset)
            vmblk_pkg::OFF_DEV_FEAT_SEL: st_d.dev_sel = vmblk_pkg::clamp_select(wd);
            vmblk_pkg::OFF_DRV_FEAT_SEL: st_d.drv_sel = vmblk_pkg::clamp_select(wd);
            vmblk_pkg::OFF_DRV_FEAT: begin
              // driver features land in the same word the device features read from
              if (st_q.drv_sel == vmblk_pkg::SEL_LOW) begin
                st_d.feature_bits[31:0] = wd;
              end else if (st_q.drv_sel == vmblk_pkg::SEL_HIGH) begin
                st_d.feature_bits[63:32] = wd;
              end
            end
            vmblk_pkg::OFF_QUEUE_NUM:   st_d.queue_length = qlen_clamped[vmblk_pkg::QlenW-1:0];
            vmblk_pkg::OFF_QUEUE_READY: st_d.queue_ready = (wd != '0);
            vmblk_pkg::OFF_QUEUE_NOTIFY: begin
              notify_o = (wd == '0) && st_q.queue_ready && (st_q.desc_addr != '0) &&
                         (st_q.avail_addr != '0) && (st_q.used_addr != '0);
            end
            vmblk_pkg::OFF_INT_ACK: st_d.int_status = st_q.int_status & ~wd;
            vmblk_pkg::OFF_STATUS: begin
              st_d.dev_status = wd;
              if (wd == '0) begin
                st_d.queue_length = '0;
                st_d.queue_ready  = 1'b0;
                st_d.desc_addr    = '0;
                st_d.avail_addr   = '0;
                st_d.used_addr    = '0;
                st_d.int_status   = '0;
              end
            end
            vmblk_pkg::OFF_DESC_LO:  st_d.desc_addr[31:0]   = wd;
            vmblk_pkg::OFF_DESC_HI:  st_d.desc_addr[63:32]  = wd;
            vmblk_pkg::OFF_AVAIL_LO: st_d.avail_addr[31:0]  = wd;
            vmblk_pkg::OFF_AVAIL_HI: st_d.avail_addr[63:32] = wd;
            vmblk_pkg::OFF_USED_LO:  st_d.used_addr[31:0]   = wd;
            vmblk_pkg::OFF_USED_HI:  st_d.used_addr[63:32]  = wd;
            default: ;
          endcase
        end
        vmblk_pkg::KIND_DONE: st_d.int_status[0] = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.feature_bits <= vmblk_pkg::OFFERED_FEATURES;
      st_q.dev_sel      <= vmblk_pkg::SEL_LOW;
      st_q.drv_sel      <= vmblk_pkg::SEL_LOW;
      st_q.queue_length <= '0;
      st_q.queue_ready  <= 1'b0;
      st_q.desc_addr    <= '0;
      st_q.avail_addr   <= '0;
      st_q.used_addr    <= '0;
      st_q.int_status   <= '0;
      st_q.dev_status   <= '0;
      cap_q             <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  assign state_o      = st_q;
  assign state_next_o = st_d;
  assign capacity_o   = cap_q;

endmodule

// ===== rtl/vmblk_rdata.sv =====
// register read decode
module vmblk_rdata (
  input  vmblk_pkg::item_t            item_i,
  input  vmblk_pkg::state_t           state_i,
  input  logic [vmblk_pkg::AddrW-1:0] capacity_i,
  output logic [vmblk_pkg::DataW-1:0] read_data_o
);

  logic [vmblk_pkg::DataW-1:0] feat_word;

  always_comb begin
    case (state_i.dev_sel)
      vmblk_pkg::SEL_LOW:  feat_word = state_i.feature_bits[31:0];
      vmblk_pkg::SEL_HIGH: feat_word = state_i.feature_bits[63:32];
      default:             feat_word = '0;
    endcase
  end

  always_comb begin
    read_data_o = '0;
    if (item_i.kind == vmblk_pkg::KIND_READ) begin
      case (item_i.offset)
        vmblk_pkg::OFF_MAGIC:       read_data_o = vmblk_pkg::MAGIC_VALUE;
        vmblk_pkg::OFF_VERSION:     read_data_o = vmblk_pkg::VERSION_VALUE;
        vmblk_pkg::OFF_DEVICE_ID:   read_data_o = vmblk_pkg::DEVICE_ID;
        vmblk_pkg::OFF_VENDOR_ID:   read_data_o = vmblk_pkg::VENDOR_VALUE;
        vmblk_pkg::OFF_DEV_FEAT:    read_data_o = feat_word;
        vmblk_pkg::OFF_QUEUE_MAX:   read_data_o = vmblk_pkg::QUEUE_SIZE;
        vmblk_pkg::OFF_QUEUE_READY: read_data_o = {31'd0, state_i.queue_ready};
        vmblk_pkg::OFF_INT_STATUS:  read_data_o = state_i.int_status;
        vmblk_pkg::OFF_STATUS:      read_data_o = state_i.dev_status;
        vmblk_pkg::OFF_CAP_LO:      read_data_o = capacity_i[31:0];
        vmblk_pkg::OFF_CAP_HI:      read_data_o = capacity_i[63:32];
        vmblk_pkg::OFF_SEG_SIZE:    read_data_o = vmblk_pkg::SEGMENT_BYTES;
        vmblk_pkg::OFF_SEG_MAX:     read_data_o = vmblk_pkg::SEGMENT_COUNT;
        vmblk_pkg::OFF_BLK_SIZE:    read_data_o = vmblk_pkg::SECTOR_BYTES;
        default:                    read_data_o = '0;
      endcase
    end
  end

endmodule

// ===== rtl/virtio_mmio_block_register_file.sv =====
// top level of the virtio-mmio block device register file
// Register front end of a virtio-mmio version 2 block device. Each item on
// item_i is a register read, a register write, or a completion event from the
// request engine, and each gives exactly one item on result_o, carrying the
// read data, a notify flag and the queue state after the update.
// An item is taken into an input register, decoded and applied to the device
// state as it moves into an output register, where its result is held until
// taken; a new item is accepted every cycle as long as the result side keeps
// up, so throughput is one item per cycle. The user must load the capacity
// register through cfg_we_i/cfg_wdata_i only while no item is in flight; the
// block itself does not enforce this.
module virtio_mmio_block_register_file_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vmblk_pkg::AddrW-1:0] cfg_wdata_i,
  vmblk_item_if.sink                  item_i,
  vmblk_result_if.source              result_o
);

  // input register
  logic              in_valid_q;
  vmblk_pkg::item_t  item_q;

  // output register
  logic                        out_valid_q;
  logic [vmblk_pkg::DataW-1:0] rd_q;
  logic                        notify_q;
  logic                        irq_q;
  logic                        qen_q;
  logic [vmblk_pkg::QlenW-1:0] qdepth_q;
  logic [vmblk_pkg::AddrW-1:0] desc_q;
  logic [vmblk_pkg::AddrW-1:0] avail_q;
  logic [vmblk_pkg::AddrW-1:0] used_q;

  logic                        advance;
  vmblk_pkg::state_t           st_cur;
  vmblk_pkg::state_t           st_next;
  logic [vmblk_pkg::AddrW-1:0] capacity;
  logic [vmblk_pkg::DataW-1:0] rdata;
  logic                        notify;

  // the held item moves on once the output register is free or being drained
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.kind       <= item_i.kind;
      item_q.offset     <= item_i.offset;
      item_q.write_data <= item_i.write_data;
    end
  end

  vmblk_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .item_i       (item_q),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .state_o      (st_cur),
    .state_next_o (st_next),
    .capacity_o   (capacity),
    .notify_o     (notify)
  );

  // reads never change state, so decoding from the current state is exact
  vmblk_rdata u_rdata (
    .item_i      (item_q),
    .state_i     (st_cur),
    .capacity_i  (capacity),
    .read_data_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result reflects the state after this item's update
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rd_q     <= rdata;
      notify_q <= notify;
      irq_q    <= (st_next.int_status != '0);
      qen_q    <= st_next.queue_ready;
      qdepth_q <= st_next.queue_length;
      desc_q   <= st_next.desc_addr;
      avail_q  <= st_next.avail_addr;
      used_q   <= st_next.used_addr;
    end
  end

  assign result_o.valid                    = out_valid_q;
  assign result_o.read_data                = rd_q;
  assign result_o.notify_request           = notify_q;
  assign result_o.interrupt_line           = irq_q;
  assign result_o.queue_enabled            = qen_q;
  assign result_o.queue_depth              = qdepth_q;
  assign result_o.descriptor_table_address = desc_q;
  assign result_o.available_ring_address   = avail_q;
  assign result_o.used_ring_address        = used_q;

endmodule
